// ===== rtl/smsort_pkg.sv =====
// ----------------------------------------------------------------------------
// smsort_pkg
// Shared widths, sizes, controller states and the command and status bundles
// that pass between the sort controller and the sort datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package smsort_pkg;

    // Field widths of one word.
    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    // Default store depth.
    localparam int MAX_ITEMS = 64;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,   // take input words
        S_PASS,   // decide whether another merge pass is needed
        S_BLOCK,  // set up the two runs of the next block
        S_MRD,    // read the heads of both runs
        S_MWR,    // compare heads and write the smaller one
        S_NEXT,   // double the run width and swap buffers
        S_ORD,    // read the next sorted entry
        S_OLD     // move it into the output register
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sort_init;
        logic block_init;
        logic merge_step;
        logic pass_next;
        logic out_init;
        logic out_load;
        logic clear_run;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass_more;
        logic step_blk_end;
        logic step_pass_end;
        logic out_free;
        logic out_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/smsort_ram.sv =====
// ----------------------------------------------------------------------------
// smsort_ram
// Generic RAM: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module smsort_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/smsort_ctrl.sv =====
// ----------------------------------------------------------------------------
// smsort_ctrl
// Sequencer for loading, the bottom-up merge passes and the output drain.
// ----------------------------------------------------------------------------
`default_nettype none

module smsort_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_last_item,
    output logic                        o_in_stall,
    input  wire smsort_pkg::t_dp_status i_status,
    output smsort_pkg::t_dp_cmd         o_cmd
);

    smsort_pkg::t_state r_state;
    smsort_pkg::t_state n_state;
    logic               in_acc;

    assign in_acc = i_in_valid && (r_state == smsort_pkg::S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smsort_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            smsort_pkg::S_IDLE: begin
                if (in_acc && i_last_item) begin
                    n_state = smsort_pkg::S_PASS;
                end
            end
            smsort_pkg::S_PASS: begin
                n_state = i_status.pass_more ? smsort_pkg::S_BLOCK : smsort_pkg::S_ORD;
            end
            smsort_pkg::S_BLOCK: n_state = smsort_pkg::S_MRD;
            smsort_pkg::S_MRD:   n_state = smsort_pkg::S_MWR;
            smsort_pkg::S_MWR: begin
                if (i_status.step_pass_end) begin
                    n_state = smsort_pkg::S_NEXT;
                end else if (i_status.step_blk_end) begin
                    n_state = smsort_pkg::S_BLOCK;
                end else begin
                    n_state = smsort_pkg::S_MRD;
                end
            end
            smsort_pkg::S_NEXT: n_state = smsort_pkg::S_PASS;
            smsort_pkg::S_ORD:  n_state = smsort_pkg::S_OLD;
            smsort_pkg::S_OLD: begin
                if (i_status.out_free) begin
                    n_state = i_status.out_last ? smsort_pkg::S_IDLE : smsort_pkg::S_ORD;
                end
            end
            default: n_state = smsort_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            smsort_pkg::S_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.load     = in_acc;
                o_cmd.sort_init = in_acc && i_last_item;
            end
            smsort_pkg::S_PASS: begin
                o_cmd.out_init = !i_status.pass_more;
            end
            smsort_pkg::S_BLOCK: o_cmd.block_init = 1'b1;
            smsort_pkg::S_MRD: begin
            end
            smsort_pkg::S_MWR:  o_cmd.merge_step = 1'b1;
            smsort_pkg::S_NEXT: o_cmd.pass_next = 1'b1;
            smsort_pkg::S_ORD: begin
            end
            smsort_pkg::S_OLD: begin
                o_cmd.out_load  = i_status.out_free;
                o_cmd.clear_run = i_status.out_free && i_status.out_last;
            end
            default: begin
            end
        endcase
    end

    // Checks on the sequencing.
    a_merge_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smsort_pkg::S_MWR) |-> ($past(r_state) == smsort_pkg::S_MRD))
        else $error("merge step without a preceding read cycle");

    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smsort_pkg::S_OLD && $past(r_state) != smsort_pkg::S_OLD)
        |-> ($past(r_state) == smsort_pkg::S_ORD))
        else $error("output load entered without a read cycle");

    a_pass_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smsort_pkg::S_PASS)
        |-> ($past(r_state) == smsort_pkg::S_IDLE || $past(r_state) == smsort_pkg::S_NEXT))
        else $error("pass check entered from an unexpected state");

endmodule

`default_nettype wire

// ===== rtl/smsort_dp.sv =====
// ----------------------------------------------------------------------------
// smsort_dp
// Two ping-pong buffers, run pointers, the merge compare and the output word
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module smsort_dp #(
    parameter int MAX_ITEMS = smsort_pkg::MAX_ITEMS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire smsort_pkg::t_dp_cmd                 i_cmd,
    output smsort_pkg::t_dp_status                   o_status,
    input  wire logic signed [smsort_pkg::KEY_W-1:0] i_key,
    input  wire logic        [smsort_pkg::TAG_W-1:0] i_tag,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed      [smsort_pkg::KEY_W-1:0] o_sorted_key,
    output logic             [smsort_pkg::TAG_W-1:0] o_sorted_tag,
    output logic                                     o_last_out,
    output logic                                     o_overflow
);

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int WID_W  = CNT_W + 1;
    localparam int SUM_W  = CNT_W + 2;
    localparam int ENT_W  = smsort_pkg::KEY_W + smsort_pkg::TAG_W;

    // Run state.
    logic [CNT_W-1:0] r_count;
    logic             r_dropped;
    logic [WID_W-1:0] r_width;
    logic [CNT_W-1:0] r_i, r_j, r_mid, r_hi, r_k;
    logic             r_src;

    // Buffer ports.
    logic [ENT_W-1:0] b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
    logic [ENT_W-1:0] rd_a, rd_b, wr_ent, b0_wdata;
    logic [ADDR_W-1:0] b0_waddr;
    logic             b0_we, b1_we, store_ok;

    // Merge signals.
    logic signed [smsort_pkg::KEY_W-1:0] key_a, key_b;
    logic             take_right;
    logic [SUM_W-1:0] sum_mid, sum_hi;
    logic [CNT_W-1:0] k_inc, i_inc, j_inc;

    // Output word register.
    logic             r_out_valid;
    logic [ENT_W-1:0] r_out_ent;
    logic             r_out_last, r_out_ovf;

    // Read data of the current source buffer.
    assign rd_a  = r_src ? b1_rd_a : b0_rd_a;
    assign rd_b  = r_src ? b1_rd_b : b0_rd_b;
    assign key_a = rd_a[ENT_W-1:smsort_pkg::TAG_W];
    assign key_b = rd_b[ENT_W-1:smsort_pkg::TAG_W];

    // Stable merge: while both runs have heads, the right run wins only on a strictly smaller key.
    assign take_right = (r_j < r_hi) && ((r_i >= r_mid) || (key_b < key_a));
    assign wr_ent     = take_right ? rd_b : rd_a;

    assign k_inc = r_k + CNT_W'(1);
    assign i_inc = r_i + CNT_W'(1);
    assign j_inc = r_j + CNT_W'(1);

    // Block bounds, clipped to the element count.
    assign sum_mid = SUM_W'(r_k) + SUM_W'(r_width);
    assign sum_hi  = SUM_W'(r_k) + SUM_W'({r_width, 1'b0});

    // Buffer write control: loading goes to buffer 0, merges to the other side.
    assign store_ok = i_cmd.load && (r_count != CNT_W'(MAX_ITEMS));
    assign b0_we    = store_ok || (i_cmd.merge_step && r_src);
    assign b1_we    = i_cmd.merge_step && !r_src;
    assign b0_wdata = i_cmd.load ? {i_key, i_tag} : wr_ent;
    assign b0_waddr = i_cmd.load ? r_count[ADDR_W-1:0] : r_k[ADDR_W-1:0];

    smsort_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf0 (
        .i_clk     (i_clk),
        .i_we      (b0_we),
        .i_waddr   (b0_waddr),
        .i_wdata   (b0_wdata),
        .i_raddr_a (r_i[ADDR_W-1:0]),
        .o_rdata_a (b0_rd_a),
        .i_raddr_b (r_j[ADDR_W-1:0]),
        .o_rdata_b (b0_rd_b)
    );

    smsort_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf1 (
        .i_clk     (i_clk),
        .i_we      (b1_we),
        .i_waddr   (r_k[ADDR_W-1:0]),
        .i_wdata   (wr_ent),
        .i_raddr_a (r_i[ADDR_W-1:0]),
        .o_rdata_a (b1_rd_a),
        .i_raddr_b (r_j[ADDR_W-1:0]),
        .o_rdata_b (b1_rd_b)
    );

    // Element count and drop flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.clear_run) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (store_ok) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.load) begin
            r_dropped <= 1'b1;
        end
    end

    // Pass width, buffer select and run pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0;
            r_src   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_mid   <= '0;
            r_hi    <= '0;
            r_k     <= '0;
        end else begin
            if (i_cmd.sort_init) begin
                r_width <= WID_W'(1);
                r_src   <= 1'b0;
                r_k     <= '0;
            end
            if (i_cmd.pass_next) begin
                r_width <= {r_width[WID_W-2:0], 1'b0};
                r_src   <= !r_src;
                r_k     <= '0;
            end
            if (i_cmd.block_init) begin
                r_i   <= r_k;
                r_mid <= (sum_mid < SUM_W'(r_count)) ? CNT_W'(sum_mid) : r_count;
                r_j   <= (sum_mid < SUM_W'(r_count)) ? CNT_W'(sum_mid) : r_count;
                r_hi  <= (sum_hi < SUM_W'(r_count)) ? CNT_W'(sum_hi) : r_count;
            end
            if (i_cmd.merge_step) begin
                r_k <= k_inc;
                if (take_right) begin
                    r_j <= j_inc;
                end else begin
                    r_i <= i_inc;
                end
            end
            if (i_cmd.out_init) begin
                r_i <= '0;
            end
            if (i_cmd.out_load) begin
                r_i <= i_inc;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ent  <= rd_a;
            r_out_last <= (i_inc == r_count);
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sorted_key = r_out_ent[ENT_W-1:smsort_pkg::TAG_W];
    assign o_sorted_tag = r_out_ent[smsort_pkg::TAG_W-1:0];
    assign o_last_out   = r_out_last;
    assign o_overflow   = r_out_ovf;

    // Status to the controller.
    assign o_status.pass_more     = r_width < WID_W'(r_count);
    assign o_status.step_blk_end  = (k_inc == r_hi);
    assign o_status.step_pass_end = (k_inc == r_count);
    assign o_status.out_free      = !r_out_valid || !i_out_stall;
    assign o_status.out_last      = (i_inc == r_count);

    // Checks on the datapath.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("element count beyond store size");

    a_merge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_step |-> (r_k < r_count))
        else $error("merge writes past the element count");

    a_merge_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_step |-> ((r_i < r_mid) || (r_j < r_hi)))
        else $error("merge step with both runs exhausted");

    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output word overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/stable_merge_sort_core.sv =====
// ----------------------------------------------------------------------------
// stable_merge_sort_core
// Collects keyed words, sorts them by signed key with a stable bottom-up merge
// sort and sends them out in ascending order.
//
//   Channel  Dir  Handshake               Payload
//   in       in   i_in_valid/o_in_stall   i_key, i_tag, i_last_item
//   out      out  o_out_valid/i_out_stall o_sorted_key, o_sorted_tag,
//                                         o_last_out, o_overflow
//
// Loading takes one word per cycle. After the word marked last, each merge
// pass handles each element with a registered RAM read, then a compare and
// write, plus a set-up step per block and a check and a buffer swap per pass.
// Draining does the same registered read, then a load, for each result.
// Reset is synchronous, active low; the buffers need no clearing pass.
// Input is stalled from the last word until the final result is in the output
// register; output stalls only hold the drain.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_merge_sort_core #(
    parameter int MAX_ITEMS = smsort_pkg::MAX_ITEMS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [smsort_pkg::KEY_W-1:0] i_key,
    input  wire logic        [smsort_pkg::TAG_W-1:0] i_tag,
    input  wire logic                                i_last_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed      [smsort_pkg::KEY_W-1:0] o_sorted_key,
    output logic             [smsort_pkg::TAG_W-1:0] o_sorted_tag,
    output logic                                     o_last_out,
    output logic                                     o_overflow
);

    smsort_pkg::t_dp_cmd    cmd;
    smsort_pkg::t_dp_status status;

    smsort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_item (i_last_item),
        .o_in_stall  (o_in_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    smsort_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_key        (i_key),
        .i_tag        (i_tag),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sorted_key (o_sorted_key),
        .o_sorted_tag (o_sorted_tag),
        .o_last_out   (o_last_out),
        .o_overflow   (o_overflow)
    );

endmodule

`default_nettype wire
